[sv/hpt_pkg.sv]
// Package with the shared types and constants of the homogeneous point transform.
package hpt_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned SUM_W  = 68;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic {
    CMD_POINT     = 1'b0,
    CMD_DIRECTION = 1'b1
  } cmd_t;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic  w_zero;
    logic  sat;
    elem_t val;
  } lane_res_t;

  localparam logic [63:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_8000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

endpackage

[sv/hpt_dot_lane.sv]
// One column lane: three products and the sum of a matrix column, over three stages.
module hpt_dot_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  hpt_pkg::elem_t vx,
  input  hpt_pkg::elem_t vy,
  input  hpt_pkg::elem_t vz,
  input  hpt_pkg::elem_t m0,
  input  hpt_pkg::elem_t m1,
  input  hpt_pkg::elem_t m2,
  input  hpt_pkg::elem_t m3,
  input  logic           translate,
  output logic signed [hpt_pkg::SUM_W-FRAC_BITS-1:0] row_sum
);
  import hpt_pkg::*;

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  sum_t s01_r, s23_r, s01_nxt, s23_nxt;
  sum_t total_r, total_nxt;

  always_comb begin
    p0_nxt = PROD_W'(vx) * PROD_W'(m0);
    p1_nxt = PROD_W'(vy) * PROD_W'(m1);
    p2_nxt = PROD_W'(vz) * PROD_W'(m2);
    p3_nxt = translate ? (PROD_W'(m3) <<< FRAC_BITS) : '0;
    s01_nxt = SUM_W'(p0_r) + SUM_W'(p1_r);
    s23_nxt = SUM_W'(p2_r) + SUM_W'(p3_r);
    total_nxt = s01_r + s23_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      s01_r <= s01_nxt;
      s23_r <= s23_nxt;
      total_r <= total_nxt;
    end
  end

  assign row_sum = total_r[SUM_W-1:FRAC_BITS];
endmodule

[sv/hpt_div_lane.sv]
// Pipelined restoring divider lane that forms the clamped quotient or passes a direction sum.
module hpt_div_lane #(
  parameter int FRAC_BITS = 16,
  parameter int NUM_W = 52
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [NUM_W-1:0] den,
  input  logic                    direct,
  output hpt_pkg::lane_res_t      res
);
  import hpt_pkg::*;

  localparam int STEPS = ELEM_W;
  localparam int STG = STEPS + 1;
  localparam int SH = ELEM_W - FRAC_BITS;

  logic [NUM_W-1:0]  d_r [STG];
  logic [NUM_W-1:0]  rem_r [STG];
  logic [ELEM_W-1:0] lo_r [STG];
  logic [STEPS-1:0]  q_r [STG];
  logic              big_r [STG];
  logic              neg_r [STG];
  logic              dir_r [STG];
  logic signed [NUM_W-1:0] raw_r [STG];

  logic [NUM_W-1:0] n_abs, d_abs, rem_init;

  assign n_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign d_abs = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
  // The top part of the shifted dividend; a quotient of 2^32 or more saturates anyway.
  assign rem_init = n_abs >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= d_abs;
      rem_r[0] <= rem_init;
      lo_r[0]  <= {n_abs[SH-1:0], {FRAC_BITS{1'b0}}};
      q_r[0]   <= '0;
      big_r[0] <= rem_init >= d_abs;
      neg_r[0] <= num[NUM_W-1] ^ den[NUM_W-1];
      dir_r[0] <= direct;
      raw_r[0] <= num;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [NUM_W:0]   trial;
    logic [NUM_W-1:0] rem_nxt;
    logic             qb;
    always_comb begin
      trial = {rem_r[s], lo_r[s][ELEM_W-1]};
      qb = trial >= {1'b0, d_r[s]};
      rem_nxt = qb ? NUM_W'(trial - {1'b0, d_r[s]}) : NUM_W'(trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s+1]   <= d_r[s];
        rem_r[s+1] <= rem_nxt;
        lo_r[s+1]  <= {lo_r[s][ELEM_W-2:0], 1'b0};
        q_r[s+1]   <= {q_r[s][STEPS-2:0], qb};
        big_r[s+1] <= big_r[s];
        neg_r[s+1] <= neg_r[s];
        dir_r[s+1] <= dir_r[s];
        raw_r[s+1] <= raw_r[s];
      end
    end
  end

  logic [ELEM_W:0] q_mag;
  logic signed [ELEM_W+1:0] q_s;
  logic signed [NUM_W-1:0] sel;
  localparam logic signed [NUM_W-1:0] MAXV = NUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [NUM_W-1:0] MINV = -NUM_W'(64'sh8000_0000);

  always_comb begin
    q_mag = big_r[STEPS] ? {1'b1, {ELEM_W{1'b0}}} : {1'b0, q_r[STEPS]};
    q_s = neg_r[STEPS] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    sel = dir_r[STEPS] ? raw_r[STEPS] : NUM_W'(q_s);
    res.w_zero = 1'b0;
    if (sel > MAXV) begin
      res.sat = 1'b1;
      res.val = 32'sh7FFF_FFFF;
    end else if (sel < MINV) begin
      res.sat = 1'b1;
      res.val = 32'sh8000_0000;
    end else begin
      res.sat = 1'b0;
      res.val = sel[31:0];
    end
  end
endmodule

[sv/homogeneous_point_transform_top.sv]
// Top level of the homogeneous point transform: registers, lanes, merge and output skid.
// Usage: write the eight matrix registers through cfg_ (index i is register i, an index
// beyond seven is dropped). Each request on in_ carries command, in_x, in_y and in_z and
// yields exactly one request on out_ with out_x, out_y, out_z, w_zero and saturated.
// Throughput is one request per cycle while the skid register is empty. A request passes 37
// register stages: 3 multiply and sum stages, 33 divider stages (operand setup plus one per
// quotient bit for 32 bits) and the output register, which drives out_valid.
// Four column lanes form x, y, z and w side by side; the merge stage applies the zero w rule.
// Reset restores the matrix to its reset values and empties the pipeline. When the
// receiver stalls, a skid register takes the next completed request; while it is full
// the whole pipeline holds and in_stall is high, so no request is lost.
module homogeneous_point_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         command,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic         out_valid,
  input  logic         out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic         w_zero,
  output logic         saturated,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [hpt_pkg::REG_IDX_W:0] cfg_index,
  input  logic [63:0]  cfg_data
);
  import hpt_pkg::*;

  localparam int NUM_W = SUM_W - FRAC_BITS;
  localparam int DIV_D = ELEM_W + 1;
  localparam int DEPTH = 3 + DIV_D;

  logic [63:0] regs_r [NUM_REGS];
  elem_t m [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= REG_RESET[i];
    end else if (cfg_valid && cfg_index[REG_IDX_W] == 1'b0) begin
      regs_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = regs_r[2*r][63:32];
      m[r][1] = regs_r[2*r][31:0];
      m[r][2] = regs_r[2*r+1][63:32];
      m[r][3] = regs_r[2*r+1][31:0];
    end
  end

  // The pipeline only moves while the skid register is empty.
  logic en;
  logic [DEPTH-1:0] vld_r;
  logic cmd_r [3];
  logic out_vld_r, skid_vld_r;
  lane_res_t out_res_r [3];
  lane_res_t skid_res_r [3];
  logic out_wz_r, skid_wz_r;
  logic out_fire;
  logic end_vld;

  assign en = !skid_vld_r;
  assign in_stall = skid_vld_r;
  assign out_fire = out_vld_r && !out_stall;
  assign end_vld = vld_r[DEPTH-1];

  // Stalls freeze the datapath by gating the clock enable on every lane.
  logic signed [NUM_W-1:0] sums [4];
  for (genvar c = 0; c < 4; c++) begin : g_dot
    hpt_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk(clk), .en(en), .vx(in_x), .vy(in_y), .vz(in_z),
      .m0(m[0][c]), .m1(m[1][c]), .m2(m[2][c]), .m3(m[3][c]),
      .translate(command == CMD_POINT), .row_sum(sums[c]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0] <= command;
      cmd_r[1] <= cmd_r[0];
      cmd_r[2] <= cmd_r[1];
    end
  end

  lane_res_t lane_res [3];
  logic is_dir;
  logic signed [NUM_W-1:0] den;
  assign is_dir = (cmd_r[2] == CMD_DIRECTION);
  assign den = (is_dir || sums[3] == '0) ? NUM_W'(1) : sums[3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    hpt_div_lane #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_div (
      .clk(clk), .en(en), .num(sums[c]), .den(den), .direct(is_dir), .res(lane_res[c]));
  end

  logic wz_r [DIV_D];
  always_ff @(posedge clk) begin
    if (en) begin
      wz_r[0] <= !is_dir && sums[3] == '0;
      for (int i = 1; i < DIV_D; i++) wz_r[i] <= wz_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_valid && !in_stall};
  end

  // The output register and skid take the merged lane results.
  logic wz_m;
  assign wz_m = wz_r[DIV_D-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) skid_vld_r <= 1'b0;
    end else if (end_vld && out_vld_r && !out_fire) begin
      skid_vld_r <= 1'b1;
    end else if (end_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        out_wz_r <= skid_wz_r;
        for (int c = 0; c < 3; c++) out_res_r[c] <= skid_res_r[c];
      end
    end else if (end_vld) begin
      if (out_vld_r && !out_fire) begin
        skid_wz_r <= wz_m;
        for (int c = 0; c < 3; c++) skid_res_r[c] <= lane_res[c];
      end else begin
        out_wz_r <= wz_m;
        for (int c = 0; c < 3; c++) out_res_r[c] <= lane_res[c];
      end
    end
  end

  assign out_valid = out_vld_r;
  assign w_zero = out_wz_r;
  assign out_x = out_wz_r ? 32'sd0 : out_res_r[0].val;
  assign out_y = out_wz_r ? 32'sd0 : out_res_r[1].val;
  assign out_z = out_wz_r ? 32'sd0 : out_res_r[2].val;
  assign saturated = !out_wz_r && (out_res_r[0].sat || out_res_r[1].sat || out_res_r[2].sat);
endmodule

[dv/homogeneous_point_transform_top_tb.sv]
// Self-checking testbench for the homogeneous point transform top level.
module homogeneous_point_transform_top_tb;
  import hpt_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_RANDOM = 1230;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } vertex_res_t;

  typedef struct {
    int          seg;
    cmd_t        cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    vertex_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_POINT;
  logic signed [31:0] in_x = '0;
  logic signed [31:0] in_y = '0;
  logic signed [31:0] in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic w_zero;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] matrix [NUM_REGS];
  vertex_res_t expected_q [$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  homogeneous_point_transform_top #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [127:0] element(int r, int c);
    logic [63:0] word;
    word = matrix[r * 2 + c / 2];
    return (c % 2) ? 128'(signed'(word[31:0])) : 128'(signed'(word[63:32]));
  endfunction

  function automatic logic signed [127:0] column_sum(int c, logic [31:0] vx, logic [31:0] vy,
                                                     logic [31:0] vz, bit translate);
    logic signed [127:0] acc;
    acc = 128'(signed'(vx)) * element(0, c) + 128'(signed'(vy)) * element(1, c)
        + 128'(signed'(vz)) * element(2, c);
    if (translate) acc = acc + (element(3, c) <<< FRAC);
    return acc >>> FRAC;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [127:0] v, inout logic sat);
    if (v > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] divide_by_w(logic signed [127:0] num,
                                              logic signed [127:0] den, inout logic sat);
    logic [127:0] n, d, qi, rem, q;
    logic signed [127:0] s;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    qi = n / d;
    rem = n % d;
    if (qi > (128'd1 << (32 - FRAC))) qi = 128'd1 << (32 - FRAC);
    q = (qi << FRAC) + ((rem << FRAC) / d);
    s = neg ? -$signed(q) : $signed(q);
    return clamp32(s, sat);
  endfunction

  function automatic vertex_res_t transform_vertex(cmd_t cmd, logic [31:0] vx,
                                                   logic [31:0] vy, logic [31:0] vz);
    vertex_res_t r;
    logic signed [127:0] w;
    r.sat = 1'b0;
    r.wz = 1'b0;
    if (cmd == CMD_DIRECTION) begin
      r.x = clamp32(column_sum(0, vx, vy, vz, 0), r.sat);
      r.y = clamp32(column_sum(1, vx, vy, vz, 0), r.sat);
      r.z = clamp32(column_sum(2, vx, vy, vz, 0), r.sat);
    end else begin
      w = column_sum(3, vx, vy, vz, 1);
      if (w == 0) begin
        r.x = '0;
        r.y = '0;
        r.z = '0;
        r.wz = 1'b1;
      end else begin
        r.x = divide_by_w(column_sum(0, vx, vy, vz, 1), w, r.sat);
        r.y = divide_by_w(column_sum(1, vx, vy, vz, 1), w, r.sat);
        r.z = divide_by_w(column_sum(2, vx, vy, vz, 1), w, r.sat);
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_res_t e;
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 13);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected output request out_x", out_x, 32'h0);
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x) report("out_x", out_x, e.x);
        if (out_y !== e.y) report("out_y", out_y, e.y);
        if (out_z !== e.z) report("out_z", out_z, e.z);
        if (w_zero !== e.wz) report("w_zero", 32'(w_zero), 32'(e.wz));
        if (saturated !== e.sat) report("saturated", 32'(saturated), 32'(e.sat));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx[REG_IDX_W:0];
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx < NUM_REGS) matrix[idx] = data;
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_vertex(cmd_t cmd, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             bit typed, vertex_res_t res);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    in_x <= vx;
    in_y <= vy;
    in_z <= vz;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(typed ? res : transform_vertex(cmd, vx, vy, vz));
  endtask

  function automatic logic [31:0] pick_value(int mode);
    logic [31:0] pool [5] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h10000};
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      default: return pool[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic logic [31:0] pick_mixed();
    int r;
    r = $urandom_range(0, 9);
    return pick_value(r < 4 ? 0 : (r < 8 ? 1 : 2));
  endfunction

  task automatic load_matrix(int mode, bit w_col_zero);
    logic [31:0] hi, lo;
    for (int i = 0; i < NUM_REGS; i++) begin
      hi = pick_value(mode);
      lo = pick_value(mode);
      if (w_col_zero && (i % 2 == 1)) lo = (i == 7) ? $urandom_range(0, 1) : 32'h0;
      write_reg(i, {hi, lo});
    end
  endtask

  task automatic load_segment(int seg);
    case (seg)
      1, 2: begin
        write_reg(0, {32'h10000, 32'h0});
        write_reg(1, 64'h0);
        write_reg(2, {32'h0, 32'h10000});
        write_reg(3, 64'h0);
        write_reg(4, 64'h0);
        write_reg(5, {32'h10000, 32'h0});
        write_reg(6, 64'h0);
        write_reg(7, (seg == 1) ? 64'h10000 : 64'h0);
      end
      3: begin
        for (int i = 8; i < 16; i++) write_reg(i, {$urandom, $urandom});
        for (int i = 0; i < NUM_REGS; i++)
          write_reg(i, (i % 3 == 0) ? 64'h80000000_80000000 : 64'h7FFFFFFF_7FFFFFFF);
      end
      4: begin
        write_reg(1, 64'h1);
        write_reg(7, 64'h0);
      end
      default: ;
    endcase
  endtask

  stim_row_t directed [] = '{
    '{0, CMD_DIRECTION, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 0, 0}},
    '{0, CMD_POINT, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 0, 0}},
    '{0, CMD_DIRECTION, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, '{0, 0, 0, 0, 0}},
    '{0, CMD_POINT, 32'h10000, 32'h0, 32'h0, 0, '{0, 0, 0, 0, 0}},
    '{0, CMD_POINT, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 0, '{0, 0, 0, 0, 0}},
    '{1, CMD_POINT, 32'h10000, 32'h20000, 32'h30000, 1,
      '{32'h10000, 32'h20000, 32'h30000, 0, 0}},
    '{1, CMD_DIRECTION, 32'hFFFF0000, 32'h8000, 32'h7FFFFFFF, 1,
      '{32'hFFFF0000, 32'h8000, 32'h7FFFFFFF, 0, 0}},
    '{1, CMD_POINT, 32'h80000000, 32'h7FFFFFFF, 32'h0, 1,
      '{32'h80000000, 32'h7FFFFFFF, 32'h0, 0, 0}},
    '{1, CMD_POINT, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 1,
      '{32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 0, 0}},
    '{2, CMD_POINT, 32'h12345678, 32'h80000000, 32'h7FFFFFFF, 1,
      '{32'h0, 32'h0, 32'h0, 1, 0}},
    '{2, CMD_POINT, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1, 0}},
    '{2, CMD_DIRECTION, 32'h80000000, 32'h10000, 32'hFFFFFFFF, 1,
      '{32'h80000000, 32'h10000, 32'hFFFFFFFF, 0, 0}},
    '{3, CMD_DIRECTION, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '{0, 0, 0, 0, 0}},
    '{3, CMD_DIRECTION, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0, 0}},
    '{3, CMD_POINT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, '{0, 0, 0, 0, 0}},
    '{3, CMD_POINT, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0, 0}},
    '{3, CMD_POINT, 32'h1, 32'h0, 32'hFFFFFFFF, 0, '{0, 0, 0, 0, 0}},
    '{4, CMD_POINT, 32'h8000, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1, 0}},
    '{4, CMD_POINT, 32'hFFFF8000, 32'h0, 32'h0, 0, '{0, 0, 0, 0, 0}},
    '{4, CMD_POINT, 32'h7FFFFFFF, 32'h10000, 32'h0, 0, '{0, 0, 0, 0, 0}},
    '{4, CMD_POINT, 32'h10000, 32'h7FFFFFFF, 32'h80000000, 0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    int seg;
    for (int i = 0; i < NUM_REGS; i++) matrix[i] = REG_RESET[i];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    seg = 0;
    foreach (directed[i]) begin
      if (directed[i].seg != seg) begin
        in_valid <= 1'b0;
        wait_idle();
        seg = directed[i].seg;
        load_segment(seg);
      end
      send_vertex(directed[i].cmd, directed[i].x, directed[i].y, directed[i].z,
                  directed[i].typed, directed[i].res);
    end
    for (int ph = 0; ph < 5; ph++) begin
      in_valid <= 1'b0;
      wait_idle();
      quiet = (ph == 4);
      load_matrix(ph == 1 ? 0 : (ph == 3 ? 2 : 1), ph == 2);
      repeat (NUM_RANDOM / 5) begin
        send_vertex($urandom_range(0, 1) ? CMD_DIRECTION : CMD_POINT,
                    pick_mixed(), pick_mixed(), pick_mixed(), 0, '{0, 0, 0, 0, 0});
      end
    end
    in_valid <= 1'b0;
    wait_idle();
    if (expected_q.size() != 0) begin
      report("output requests never arrived", 32'(expected_q.size()), 32'h0);
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
